>>> design/hsv_to_argb_pixel_convert_assert.svh
// ----------------------------------------------------------------------------
// hsv to argb converter assertion macros
// concurrent check wrappers, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef HSV_TO_ARGB_PIXEL_CONVERT_ASSERT_SVH
`define HSV_TO_ARGB_PIXEL_CONVERT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HSVC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsvc implication check failed");

// next-cycle implication
`define HSVC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsvc next-cycle check failed");

`else

`define HSVC_ASSERT_IMPLY(name, clk, rst, ante, cons)

`define HSVC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> design/hsvc_pkg.sv
// ----------------------------------------------------------------------------
// hsvc_pkg
// shared types, constants and helpers of the hsv to argb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsvc_pkg;

   localparam int HSVC_HUE_FRAC_BITS_DEF  = 6;
   localparam int HSVC_UNIT_FRAC_BITS_DEF = 8;

   localparam logic [7:0] CHAN_MAX = 8'hFF;

   // what a color channel carries before the m offset
   typedef enum logic [1:0] {
      ROLE_CHROMA = 2'd0,
      ROLE_X      = 2'd1,
      ROLE_ZERO   = 2'd2
   } role_type;

   typedef struct packed {
      role_type red;
      role_type green;
      role_type blue;
   } rgb_role_type;

   // stage advance enables for the back stages
   typedef struct packed {
      logic en2;
      logic en3;
      logic en4;
   } pipe_en_type;

   // one 60 degree sector in hue units: 60 * 2^hfb = 15 * 2^(hfb+2)
   function automatic int sector_len(input int hue_frac_bits);
      return 15 << (hue_frac_bits + 2);
   endfunction

   function automatic rgb_role_type sector_roles(input logic [2:0] sector);
      rgb_role_type r;
      case (sector)
         3'd0: r = '{ROLE_CHROMA, ROLE_X, ROLE_ZERO};
         3'd1: r = '{ROLE_X, ROLE_CHROMA, ROLE_ZERO};
         3'd2: r = '{ROLE_ZERO, ROLE_CHROMA, ROLE_X};
         3'd3: r = '{ROLE_ZERO, ROLE_X, ROLE_CHROMA};
         3'd4: r = '{ROLE_X, ROLE_ZERO, ROLE_CHROMA};
         default: r = '{ROLE_CHROMA, ROLE_ZERO, ROLE_X};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/hsvc_front.sv
// ----------------------------------------------------------------------------
// hsvc_front
// stage 1: hue range check, sector index, distance to the center of the sector pair, alpha
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_front
   import hsvc_pkg::*;
#(
   parameter int HUE_FRAC_BITS  = HSVC_HUE_FRAC_BITS_DEF,
   parameter int UNIT_FRAC_BITS = HSVC_UNIT_FRAC_BITS_DEF,
   localparam int EW = $clog2(sector_len(HUE_FRAC_BITS) + 1)
) (
   input  wire logic               clock,
   input  wire logic               en1,
   input  wire logic signed [15:0] hue,
   input  wire logic [8:0]         saturation,
   input  wire logic [8:0]         brightness,
   input  wire logic [8:0]         opacity,
   output logic                    hue_ok_ff,
   output rgb_role_type            roles_ff,
   output logic [EW-1:0]           dist_ff,
   output logic [8:0]              sat_ff,
   output logic [8:0]              bright_ff,
   output logic [7:0]              alpha_ff
);

   localparam int SEC_D   = sector_len(HUE_FRAC_BITS);
   localparam int HUE_MAX = 360 << HUE_FRAC_BITS;
   localparam int HMAX_W  = $clog2(HUE_MAX + 1);
   localparam int CW      = (HMAX_W > 15) ? HMAX_W : 15;

   logic [CW-1:0] hmag;
   logic          hue_ok_in;
   logic [2:0]    sector;
   logic [CW-1:0] base;
   logic [CW-1:0] t;
   logic [EW-1:0] dist_in;
   logic [16:0]   a_scaled;
   logic [16:0]   a_shift;
   logic [7:0]    alpha_in;

   always_comb begin
      hmag      = CW'(hue[14:0]);
      hue_ok_in = !hue[15] && (hmag <= CW'(HUE_MAX));

      // sector index from six threshold compares
      sector = 3'd0;
      for (int i = 1; i <= 6; i++) begin
         if (hmag >= CW'(i * SEC_D)) begin
            sector = 3'(i);
         end
      end

      // hue mod two sectors
      case (sector[2:1])
         2'd0: base = '0;
         2'd1: base = CW'(2 * SEC_D);
         2'd2: base = CW'(4 * SEC_D);
         default: base = CW'(6 * SEC_D);
      endcase
      t = hmag - base;

      if (t >= CW'(SEC_D)) begin
         dist_in = EW'(t - CW'(SEC_D));
      end else begin
         dist_in = EW'(CW'(SEC_D) - t);
      end

      // 255 * opacity, truncated and saturated
      a_scaled = {opacity, 8'd0} - 17'(opacity);
      a_shift  = a_scaled >> UNIT_FRAC_BITS;
      if (!hue_ok_in || (a_shift > 17'(CHAN_MAX))) begin
         alpha_in = CHAN_MAX;
      end else begin
         alpha_in = a_shift[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         hue_ok_ff <= hue_ok_in;
         roles_ff  <= sector_roles(sector);
         dist_ff   <= dist_in;
         sat_ff    <= saturation;
         bright_ff <= brightness;
         alpha_ff  <= alpha_in;
      end
   end

endmodule

`default_nettype wire

>>> design/hsvc_lane.sv
// ----------------------------------------------------------------------------
// hsvc_lane
// stages 2 to 4 of one color channel: weight, scale by value, byte out
// ----------------------------------------------------------------------------
`default_nettype none

module hsvc_lane
   import hsvc_pkg::*;
#(
   parameter int HUE_FRAC_BITS  = HSVC_HUE_FRAC_BITS_DEF,
   parameter int UNIT_FRAC_BITS = HSVC_UNIT_FRAC_BITS_DEF,
   localparam int EW = $clog2(sector_len(HUE_FRAC_BITS) + 1)
) (
   input  wire logic          clock,
   input  wire pipe_en_type   pipe_en,
   input  wire logic          hue_ok,
   input  wire role_type      role,
   input  wire logic [EW-1:0] hue_dist,
   input  wire logic [8:0]    saturation,
   input  wire logic [8:0]    brightness,
   output logic [7:0]         chan_ff
);

   localparam int SEC_D = sector_len(HUE_FRAC_BITS);
   localparam int DU    = SEC_D << UNIT_FRAC_BITS;
   localparam int DUW   = $clog2(DU + 1);
   localparam int SEW   = 9 + EW;
   localparam int GW    = ((DUW > SEW) ? DUW : SEW) + 1;
   localparam int PW    = GW - 1 + 9;
   localparam int XW    = PW + 5;
   // 255 / (U*U*D) reduces to 17 / 2^SHIFT
   localparam int SHIFT = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 2;

   logic [EW-1:0]        e;
   logic [SEW-1:0]       se;
   logic signed [GW-1:0] g_in;
   logic signed [GW-1:0] g_ff;
   logic [8:0]           bright2_ff;
   logic                 ok2_ff;
   logic [GW-2:0]        gpos;
   logic [PW-1:0]        p_in;
   logic [PW-1:0]        p_ff;
   logic                 ok3_ff;
   logic [XW-1:0]        x17;
   logic [XW-1:0]        scaled;
   logic [7:0]           chan_in;

   // stage 2: g = D*U - S*e, e picks chroma, x or zero
   always_comb begin
      case (role)
         ROLE_CHROMA: e = '0;
         ROLE_X:      e = hue_dist;
         ROLE_ZERO:   e = EW'(SEC_D);
         default:     e = EW'(SEC_D);
      endcase
      se   = SEW'(saturation) * SEW'(e);
      g_in = $signed(GW'(DU)) - $signed(GW'(se));
   end

   always_ff @(posedge clock) begin
      if (pipe_en.en2) begin
         g_ff       <= g_in;
         bright2_ff <= brightness;
         ok2_ff     <= hue_ok;
      end
   end

   // stage 3: scale by value; non-positive numerators give zero
   always_comb begin
      gpos = (g_ff > 0) ? g_ff[GW-2:0] : '0;
      p_in = PW'(bright2_ff) * PW'(gpos);
   end

   always_ff @(posedge clock) begin
      if (pipe_en.en3) begin
         p_ff   <= p_in;
         ok3_ff <= ok2_ff;
      end
   end

   // stage 4: times 17, shift, saturate; zero for a hue out of range
   always_comb begin
      x17    = XW'({p_ff, 4'd0}) + XW'(p_ff);
      scaled = x17 >> SHIFT;
      if (!ok3_ff) begin
         chan_in = '0;
      end else if (scaled > XW'(CHAN_MAX)) begin
         chan_in = CHAN_MAX;
      end else begin
         chan_in = scaled[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.en4) begin
         chan_ff <= chan_in;
      end
   end

endmodule

`default_nettype wire

>>> design/hsv_to_argb_pixel_convert.sv
// ----------------------------------------------------------------------------
// hsv_to_argb_pixel_convert
// hsv pixel with alpha in, 8-bit argb out, four-stage pipeline
// ----------------------------------------------------------------------------
// usage
//   req_* carries one hsv item: signed hue in 1/2^HUE_FRAC_BITS degree,
//   saturation, brightness and opacity with 2^UNIT_FRAC_BITS meaning 1.0
//   rsp_* carries one argb item per input item, in the same order
//   both channels are valid/ready; an item moves when valid and ready are high
// pipeline and throughput
//   four register stages (front, weight, value multiply, byte out), which an
//   item passes through in that order
//   one item per cycle sustained while rsp_ready is high: each stage advances
//   when it is empty or the stage after it advances
// hue outside 0..360 degrees gives opaque black (alpha 255, color zero)
// reset
//   synchronous, active high; clears every stage valid bit, so the pipe is
//   empty and req_ready is high on the first cycle after reset
// stall
//   with rsp_ready low the output item holds, stages fill behind it and
//   req_ready drops only once all four stages hold an item
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_argb_pixel_convert_assert.svh"

module hsv_to_argb_pixel_convert
   import hsvc_pkg::*;
#(
   parameter int HUE_FRAC_BITS  = HSVC_HUE_FRAC_BITS_DEF,
   parameter int UNIT_FRAC_BITS = HSVC_UNIT_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [15:0] req_hue,
   input  wire logic [8:0]         req_saturation,
   input  wire logic [8:0]         req_brightness,
   input  wire logic [8:0]         req_opacity,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_alpha_out,
   output logic [7:0]              rsp_red_out,
   output logic [7:0]              rsp_green_out,
   output logic [7:0]              rsp_blue_out
);

   localparam int EW = $clog2(sector_len(HUE_FRAC_BITS) + 1);

   // stage valid bits
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;
   logic v4_ff;

   // alpha rides alongside the color lanes
   logic [7:0] alpha2_ff;
   logic [7:0] alpha3_ff;
   logic [7:0] alpha4_ff;

   logic        en1;
   pipe_en_type pipe_en;

   // stage 1 outputs
   logic          f_ok;
   rgb_role_type  f_roles;
   logic [EW-1:0] f_dist;
   logic [8:0]    f_sat;
   logic [8:0]    f_bright;
   logic [7:0]    f_alpha;

   // a stage advances when empty or when the next one advances
   always_comb begin
      pipe_en.en4 = !v4_ff || rsp_ready;
      pipe_en.en3 = !v3_ff || pipe_en.en4;
      pipe_en.en2 = !v2_ff || pipe_en.en3;
      en1         = !v1_ff || pipe_en.en2;
   end

   assign req_ready     = en1;
   assign rsp_valid     = v4_ff;
   assign rsp_alpha_out = alpha4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (pipe_en.en2) begin
            v2_ff <= v1_ff;
         end
         if (pipe_en.en3) begin
            v3_ff <= v2_ff;
         end
         if (pipe_en.en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en.en2) begin
         alpha2_ff <= f_alpha;
      end
      if (pipe_en.en3) begin
         alpha3_ff <= alpha2_ff;
      end
      if (pipe_en.en4) begin
         alpha4_ff <= alpha3_ff;
      end
   end

   // range check, sector, distance to the center of the sector pair and alpha
   hsvc_front #(
      .HUE_FRAC_BITS  (HUE_FRAC_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .en1        (en1),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .opacity    (req_opacity),
      .hue_ok_ff  (f_ok),
      .roles_ff   (f_roles),
      .dist_ff    (f_dist),
      .sat_ff     (f_sat),
      .bright_ff  (f_bright),
      .alpha_ff   (f_alpha)
   );

   // one lane per color channel
   hsvc_lane #(
      .HUE_FRAC_BITS  (HUE_FRAC_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_lane_red (
      .clock      (clock),
      .pipe_en    (pipe_en),
      .hue_ok     (f_ok),
      .role       (f_roles.red),
      .hue_dist   (f_dist),
      .saturation (f_sat),
      .brightness (f_bright),
      .chan_ff    (rsp_red_out)
   );

   hsvc_lane #(
      .HUE_FRAC_BITS  (HUE_FRAC_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_lane_green (
      .clock      (clock),
      .pipe_en    (pipe_en),
      .hue_ok     (f_ok),
      .role       (f_roles.green),
      .hue_dist   (f_dist),
      .saturation (f_sat),
      .brightness (f_bright),
      .chan_ff    (rsp_green_out)
   );

   hsvc_lane #(
      .HUE_FRAC_BITS  (HUE_FRAC_BITS),
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
   ) u_lane_blue (
      .clock      (clock),
      .pipe_en    (pipe_en),
      .hue_ok     (f_ok),
      .role       (f_roles.blue),
      .hue_dist   (f_dist),
      .saturation (f_sat),
      .brightness (f_bright),
      .chan_ff    (rsp_blue_out)
   );

   // item count in flight follows the two handshakes
   logic [3:0] vbits;
   logic [2:0] fill_cnt;
   logic       in_acc;
   logic       out_acc;

   assign vbits    = {v4_ff, v3_ff, v2_ff, v1_ff};
   assign fill_cnt = 3'($countones(vbits));
   assign in_acc   = req_valid && req_ready;
   assign out_acc  = rsp_valid && rsp_ready;

   `HSVC_ASSERT_NEXT(a_fill, clock, reset, in_acc && !out_acc, fill_cnt == $past(fill_cnt) + 3'd1)
   `HSVC_ASSERT_NEXT(a_drain, clock, reset, out_acc && !in_acc, fill_cnt + 3'd1 == $past(fill_cnt))
   `HSVC_ASSERT_NEXT(a_pass, clock, reset, in_acc && out_acc, fill_cnt == $past(fill_cnt))

endmodule

`default_nettype wire
